// File: rtl/core/vls_pkg.sv
// vls_pkg: shared types and constants for the vehicle longitudinal step block
// no dependencies; used by vls_alu and vehicle_longitudinal_step
`default_nettype none

package vls_pkg;

    // signed working value: holds 48-bit magnitudes and 32-bit unsigned registers
    typedef logic signed [48:0] val_t;

    // request from the sequencer to the shared arithmetic unit
    typedef struct packed {
        logic start;
        logic is_div;
        logic lim32;
    } alu_req_t;

    // answer from the shared arithmetic unit
    typedef struct packed {
        logic done;
        val_t result;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIN
    } alu_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } seq_state_t;

    typedef enum logic [3:0] {
        OP_RPM_DIV,
        OP_RPM_RATIO,
        OP_RPM_FD,
        OP_RPM_K,
        OP_F_CURVE,
        OP_F_FD,
        OP_F_RATIO,
        OP_F_EFF,
        OP_F_DIV,
        OP_CAP,
        OP_DRAG_SQ,
        OP_DRAG,
        OP_ROLL,
        OP_ACC,
        OP_SPEED,
        OP_DIST
    } op_t;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_CURVE = 2'd1;
    localparam logic [1:0] KIND_GEAR  = 2'd2;

    // register indexes on the config port
    localparam logic [1:0] REG_RPM_LIMIT   = 2'd0;
    localparam logic [1:0] REG_FINAL_DRIVE = 2'd1;
    localparam logic [1:0] REG_WHEEL_RAD   = 2'd2;
    localparam logic [1:0] REG_MASS        = 2'd3;

    // register reset values
    localparam logic [14:0] RST_RPM_LIMIT   = 15'd8000;
    localparam logic [31:0] RST_FINAL_DRIVE = 32'd262144;
    localparam logic [31:0] RST_WHEEL_RAD   = 32'd19661;
    localparam logic [31:0] RST_MASS        = 32'd65536000;

    // Q16.16 constants
    localparam val_t K_EFF  = 49'sd45875;
    localparam val_t K_DRAG = 49'sd26493;
    localparam val_t K_ROLL = 49'sd794788;
    localparam val_t K_TRAC = 49'sd321126;
    localparam val_t K_RPM  = 49'sd625823;

    localparam logic [13:0] RPM_IDLE   = 14'd1000;
    localparam val_t        RPM_IDLE_Q = 49'sd65536000;

    // saturation limits
    localparam logic [47:0] LIM48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] LIM32 = 48'h0000_7FFF_FFFF;

    // iteration counts of the shared unit (last step index)
    localparam logic [5:0] MUL_LAST = 6'd2;
    localparam logic [5:0] DIV_LAST = 6'd62;

endpackage

`default_nettype wire

// File: rtl/core/vls_alu.sv
// vls_alu: shared multi-cycle multiply / divide unit, Q16.16 with saturation
// depends on vls_pkg
`default_nettype none

module vls_alu (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vls_pkg::alu_req_t req,
    input  wire vls_pkg::val_t    op_a,
    input  wire vls_pkg::val_t    op_b,
    output vls_pkg::alu_rsp_t     rsp
);

    vls_pkg::alu_state_t state_reg, state_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [95:0] acc_reg, acc_next;
    logic [47:0] a_reg, a_next;
    logic [47:0] b_reg, b_next;
    logic [48:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic        div_reg, div_next;
    logic        lim32_reg, lim32_next;
    logic        zero_reg, zero_next;
    logic        ovf_reg, ovf_next;
    vls_pkg::val_t result_reg, result_next;

    logic [48:0] abs_a, abs_b;
    logic [47:0] mag_a, mag_b;
    logic [46:0] ua;
    logic [63:0] part;
    logic [48:0] rsh;
    logic        ge;
    logic [79:0] raw;
    logic        over;
    logic [47:0] limv;
    logic [47:0] magr;

    // operand magnitudes
    assign abs_a = op_a[48] ? -op_a : op_a;
    assign abs_b = op_b[48] ? -op_b : op_b;
    assign mag_a = abs_a[47:0];
    assign mag_b = abs_b[47:0];
    assign ua    = mag_a[47] ? vls_pkg::LIM48[46:0] : mag_a[46:0];

    // one 48x16 partial product per step
    assign part = a_reg * b_reg[47:32];

    // one restoring divide step
    assign rsh = {rem_reg[47:0], acc_reg[62]};
    assign ge  = rsh >= {1'b0, b_reg};

    // saturation of the finished magnitude
    assign raw  = div_reg ? {17'b0, acc_reg[62:0]} : acc_reg[95:16];
    assign over = lim32_reg ? (|raw[79:31]) : (|raw[79:47]);
    assign limv = lim32_reg ? vls_pkg::LIM32 : vls_pkg::LIM48;
    assign magr = zero_reg ? 48'd0 : ((ovf_reg || over) ? limv : raw[47:0]);

    // sequencing of the unit
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        div_next    = div_reg;
        lim32_next  = lim32_reg;
        zero_next   = zero_reg;
        ovf_next    = ovf_reg;
        result_next = result_reg;
        unique case (state_reg)
            vls_pkg::ALU_IDLE:
            begin
                if (req.start)
                begin
                    neg_next   = op_a[48] ^ op_b[48];
                    div_next   = req.is_div;
                    lim32_next = req.lim32;
                    cnt_next   = 6'd0;
                    a_next     = mag_a;
                    b_next     = mag_b;
                    rem_next   = 49'd0;
                    zero_next  = 1'b0;
                    ovf_next   = 1'b0;
                    if (req.is_div)
                    begin
                        acc_next  = {33'b0, ua, 16'b0};
                        zero_next = (ua == 47'd0);
                        ovf_next  = (mag_b == 48'd0);
                        if ((ua == 47'd0) || (mag_b == 48'd0))
                            state_next = vls_pkg::ALU_FIN;
                        else
                            state_next = vls_pkg::ALU_DIV;
                    end
                    else
                    begin
                        acc_next   = 96'd0;
                        state_next = vls_pkg::ALU_MUL;
                    end
                end
            end
            vls_pkg::ALU_MUL:
            begin
                acc_next = {acc_reg[79:0], 16'b0} + {32'b0, part};
                b_next   = {b_reg[31:0], 16'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == vls_pkg::MUL_LAST)
                    state_next = vls_pkg::ALU_FIN;
            end
            vls_pkg::ALU_DIV:
            begin
                rem_next = ge ? (rsh - {1'b0, b_reg}) : rsh;
                acc_next = {acc_reg[95:63], acc_reg[61:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == vls_pkg::DIV_LAST)
                    state_next = vls_pkg::ALU_FIN;
            end
            vls_pkg::ALU_FIN:
            begin
                result_next = neg_reg ? -{1'b0, magr} : {1'b0, magr};
                done_next   = 1'b1;
                state_next  = vls_pkg::ALU_IDLE;
            end
            default:
            begin
                state_next = vls_pkg::ALU_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vls_pkg::ALU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        div_reg    <= div_next;
        lim32_reg  <= lim32_next;
        zero_reg   <= zero_next;
        ovf_reg    <= ovf_next;
        result_reg <= result_next;
    end

    assign rsp = {done_reg, result_reg};

endmodule

`default_nettype wire

// File: rtl/core/vehicle_longitudinal_step.sv
// A load word goes from ST_IDLE to ST_OUT, which registers the result word when
// the result slot is free. A tick runs its multiplies and divides in turn on the
// shared multiply/divide unit: three divides (two in neutral), each at one quotient
// bit per cycle. One word at a time: item_ready is high only while idle.
// Reset clears speed, distance, control state and the config registers; the
// curve and gear tables hold no reset value and need no clearing pass.
`default_nettype none

module vehicle_longitudinal_step #(
    parameter int CURVE_DEPTH  = 16384,
    parameter int GEAR_ENTRIES = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // config port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // item channel
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [1:0]         kind,
    input  wire logic [16:0]        throttle,
    input  wire logic [3:0]         gear_select,
    input  wire logic [15:0]        time_step,
    input  wire logic [13:0]        table_index,
    input  wire logic signed [31:0] table_value,
    // result channel
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [13:0]             engine_rpm,
    output logic signed [47:0]      drive_force,
    output logic signed [31:0]      accel_out,
    output logic signed [31:0]      speed_out,
    output logic signed [47:0]      distance_out,
    output logic                    traction_capped
);

    localparam int CURVE_AW = $clog2(CURVE_DEPTH);
    localparam int GEAR_AW  = $clog2(GEAR_ENTRIES);
    localparam int RPM_CAP  = (CURVE_DEPTH - 1 < 16383) ? CURVE_DEPTH - 1 : 16383;

    // config registers
    logic [14:0] rpm_limit_reg;
    logic [31:0] final_drive_reg;
    logic [31:0] wheel_rad_reg;
    logic [31:0] mass_reg;

    // tables
    logic signed [31:0] curve_mem [CURVE_DEPTH];
    logic signed [31:0] gear_tab  [GEAR_ENTRIES];
    logic signed [31:0] curve_rd_reg;

    // sequencer and working registers
    vls_pkg::seq_state_t state_reg, state_next;
    vls_pkg::op_t        op_reg, op_next;
    logic [13:0]        rpm_reg, rpm_next;
    vls_pkg::val_t      q_reg, q_next;
    vls_pkg::val_t      f_reg, f_next;
    vls_pkg::val_t      t_reg, t_next;
    logic signed [31:0] acc_reg, acc_next;
    logic               capped_reg, capped_next;
    logic signed [31:0] speed_reg, speed_next;
    logic signed [47:0] dist_reg, dist_next;
    logic [16:0]        thr_reg, thr_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [31:0] ratio_reg, ratio_next;

    // result registers
    logic               out_valid_reg, out_valid_next;
    logic [13:0]        out_rpm_reg;
    logic signed [47:0] out_force_reg;
    logic signed [31:0] out_acc_reg;
    logic signed [31:0] out_speed_reg;
    logic signed [47:0] out_dist_reg;
    logic               out_capped_reg;
    logic               out_load;

    vls_pkg::alu_req_t alu_req;
    vls_pkg::alu_rsp_t alu_rsp;
    vls_pkg::val_t     alu_a, alu_b;

    logic        item_fire;
    logic        cfg_write;
    logic [14:0] lim_m1;
    logic [13:0] upper;
    logic [13:0] rpm_idle_cl;
    logic [31:0] rpm_cand;
    logic [13:0] rpm_calc;
    logic [31:0] speed_abs;
    logic signed [50:0] net_w;
    vls_pkg::val_t      net_sat;
    logic signed [49:0] spd_w;
    logic signed [31:0] spd_sat;
    logic signed [49:0] dst_w;
    logic signed [47:0] dst_sat;

    assign item_ready = (state_reg == vls_pkg::ST_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_limit_reg   <= vls_pkg::RST_RPM_LIMIT;
            final_drive_reg <= vls_pkg::RST_FINAL_DRIVE;
            wheel_rad_reg   <= vls_pkg::RST_WHEEL_RAD;
            mass_reg        <= vls_pkg::RST_MASS;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                vls_pkg::REG_RPM_LIMIT:   rpm_limit_reg   <= pwdata[14:0];
                vls_pkg::REG_FINAL_DRIVE: final_drive_reg <= pwdata;
                vls_pkg::REG_WHEEL_RAD:   wheel_rad_reg   <= pwdata;
                vls_pkg::REG_MASS:        mass_reg        <= pwdata;
                default:                  rpm_limit_reg   <= rpm_limit_reg;
            endcase
        end
    end

    // config readback
    always_comb
    begin
        unique case (paddr[3:2])
            vls_pkg::REG_RPM_LIMIT:   prdata = {17'b0, rpm_limit_reg};
            vls_pkg::REG_FINAL_DRIVE: prdata = final_drive_reg;
            vls_pkg::REG_WHEEL_RAD:   prdata = wheel_rad_reg;
            vls_pkg::REG_MASS:        prdata = mass_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    // power curve memory: load writes, one registered read per tick
    always_ff @(posedge clk)
    begin
        if (item_fire && (kind == vls_pkg::KIND_CURVE) && (32'(table_index) < CURVE_DEPTH))
            curve_mem[CURVE_AW'(table_index)] <= table_value;
        if (state_reg == vls_pkg::ST_READ)
            curve_rd_reg <= curve_mem[CURVE_AW'(rpm_reg)];
    end

    // gear ratio table
    always_ff @(posedge clk)
    begin
        if (item_fire && (kind == vls_pkg::KIND_GEAR) && (32'(table_index) < GEAR_ENTRIES))
            gear_tab[GEAR_AW'(table_index)] <= table_value;
    end

    // rpm window and clamping
    assign lim_m1      = (rpm_limit_reg == 15'd0) ? 15'd0 : rpm_limit_reg - 15'd1;
    assign upper       = (lim_m1 > 15'(RPM_CAP)) ? 14'(RPM_CAP) : lim_m1[13:0];
    assign rpm_idle_cl = (vls_pkg::RPM_IDLE > upper) ? upper : vls_pkg::RPM_IDLE;
    assign rpm_cand    = (alu_rsp.result >= vls_pkg::RPM_IDLE_Q) ?
                         alu_rsp.result[47:16] : {18'b0, vls_pkg::RPM_IDLE};
    assign rpm_calc    = (rpm_cand > {18'b0, upper}) ? upper : rpm_cand[13:0];

    assign speed_abs = speed_reg[31] ? -speed_reg : speed_reg;

    // net force: force - drag - rolling, saturated
    assign net_w = {{2{f_reg[48]}}, f_reg} - {{2{t_reg[48]}}, t_reg}
                 - {{2{alu_rsp.result[48]}}, alu_rsp.result};
    always_comb
    begin
        if (net_w > $signed({3'b0, vls_pkg::LIM48}))
            net_sat = {1'b0, vls_pkg::LIM48};
        else if (net_w < -$signed({3'b0, vls_pkg::LIM48}))
            net_sat = -{1'b0, vls_pkg::LIM48};
        else
            net_sat = net_w[48:0];
    end

    // speed update, saturated to 32 bits
    assign spd_w = {{18{speed_reg[31]}}, speed_reg} + {alu_rsp.result[48], alu_rsp.result};
    always_comb
    begin
        if (spd_w > $signed({2'b0, vls_pkg::LIM32}))
            spd_sat = 32'sh7FFF_FFFF;
        else if (spd_w < -$signed({2'b0, vls_pkg::LIM32}))
            spd_sat = -32'sh7FFF_FFFF;
        else
            spd_sat = spd_w[31:0];
    end

    // distance update, saturated to 48 bits
    assign dst_w = {{2{dist_reg[47]}}, dist_reg} + {alu_rsp.result[48], alu_rsp.result};
    always_comb
    begin
        if (dst_w > $signed({2'b0, vls_pkg::LIM48}))
            dst_sat = vls_pkg::LIM48;
        else if (dst_w < -$signed({2'b0, vls_pkg::LIM48}))
            dst_sat = -vls_pkg::LIM48;
        else
            dst_sat = dst_w[47:0];
    end

    // operand select for the shared unit
    always_comb
    begin
        alu_a         = q_reg;
        alu_b         = q_reg;
        alu_req.is_div = 1'b0;
        alu_req.lim32  = 1'b0;
        alu_req.start  = (state_reg == vls_pkg::ST_ISSUE);
        unique case (op_reg)
            vls_pkg::OP_RPM_DIV:
            begin
                alu_a = {{17{speed_reg[31]}}, speed_reg};
                alu_b = {17'b0, wheel_rad_reg};
                alu_req.is_div = 1'b1;
            end
            vls_pkg::OP_RPM_RATIO:
            begin
                alu_a = q_reg;
                alu_b = {{17{ratio_reg[31]}}, ratio_reg};
            end
            vls_pkg::OP_RPM_FD:
            begin
                alu_a = q_reg;
                alu_b = {17'b0, final_drive_reg};
            end
            vls_pkg::OP_RPM_K:
            begin
                alu_a = q_reg;
                alu_b = vls_pkg::K_RPM;
            end
            vls_pkg::OP_F_CURVE:
            begin
                alu_a = {32'b0, thr_reg};
                alu_b = {{17{curve_rd_reg[31]}}, curve_rd_reg};
            end
            vls_pkg::OP_F_FD:
            begin
                alu_a = f_reg;
                alu_b = {17'b0, final_drive_reg};
            end
            vls_pkg::OP_F_RATIO:
            begin
                alu_a = f_reg;
                alu_b = {{17{ratio_reg[31]}}, ratio_reg};
            end
            vls_pkg::OP_F_EFF:
            begin
                alu_a = f_reg;
                alu_b = vls_pkg::K_EFF;
            end
            vls_pkg::OP_F_DIV:
            begin
                alu_a = f_reg;
                alu_b = {17'b0, wheel_rad_reg};
                alu_req.is_div = 1'b1;
            end
            vls_pkg::OP_CAP:
            begin
                alu_a = {17'b0, mass_reg};
                alu_b = vls_pkg::K_TRAC;
            end
            vls_pkg::OP_DRAG_SQ:
            begin
                alu_a = {{17{speed_reg[31]}}, speed_reg};
                alu_b = {17'b0, speed_abs};
            end
            vls_pkg::OP_DRAG:
            begin
                alu_a = vls_pkg::K_DRAG;
                alu_b = t_reg;
            end
            vls_pkg::OP_ROLL:
            begin
                alu_a = vls_pkg::K_ROLL;
                alu_b = {{17{speed_reg[31]}}, speed_reg};
            end
            vls_pkg::OP_ACC:
            begin
                alu_a = q_reg;
                alu_b = {17'b0, mass_reg};
                alu_req.is_div = 1'b1;
                alu_req.lim32  = 1'b1;
            end
            vls_pkg::OP_SPEED:
            begin
                alu_a = {33'b0, dt_reg};
                alu_b = {{17{acc_reg[31]}}, acc_reg};
                alu_req.lim32 = 1'b1;
            end
            vls_pkg::OP_DIST:
            begin
                alu_a = {33'b0, dt_reg};
                alu_b = {{17{speed_reg[31]}}, speed_reg};
            end
            default:
            begin
                alu_a = q_reg;
            end
        endcase
    end

    vls_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .op_a  (alu_a),
        .op_b  (alu_b),
        .rsp   (alu_rsp)
    );

    // sequencer: next state and working register updates
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rpm_next       = rpm_reg;
        q_next         = q_reg;
        f_next         = f_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        capped_next    = capped_reg;
        speed_next     = speed_reg;
        dist_next      = dist_reg;
        thr_next       = thr_reg;
        dt_next        = dt_reg;
        ratio_next     = ratio_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        unique case (state_reg)
            vls_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    rpm_next    = 14'd0;
                    f_next      = '0;
                    acc_next    = 32'sd0;
                    capped_next = 1'b0;
                    thr_next    = throttle;
                    dt_next     = time_step;
                    ratio_next  = (32'(gear_select) < GEAR_ENTRIES) ?
                                  gear_tab[GEAR_AW'(gear_select)] : 32'sd0;
                    if (kind == vls_pkg::KIND_TICK)
                    begin
                        if (gear_select == 4'd1)
                        begin
                            rpm_next   = rpm_idle_cl;
                            op_next    = vls_pkg::OP_F_CURVE;
                            state_next = vls_pkg::ST_READ;
                        end
                        else
                        begin
                            op_next    = vls_pkg::OP_RPM_DIV;
                            state_next = vls_pkg::ST_ISSUE;
                        end
                    end
                    else
                    begin
                        state_next = vls_pkg::ST_OUT;
                    end
                end
            end
            vls_pkg::ST_READ:
            begin
                state_next = vls_pkg::ST_ISSUE;
            end
            vls_pkg::ST_ISSUE:
            begin
                state_next = vls_pkg::ST_WAIT;
            end
            vls_pkg::ST_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    state_next = vls_pkg::ST_ISSUE;
                    case (op_reg)
                        vls_pkg::OP_RPM_DIV:
                        begin
                            q_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_RPM_RATIO;
                        end
                        vls_pkg::OP_RPM_RATIO:
                        begin
                            q_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_RPM_FD;
                        end
                        vls_pkg::OP_RPM_FD:
                        begin
                            q_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_RPM_K;
                        end
                        vls_pkg::OP_RPM_K:
                        begin
                            rpm_next   = rpm_calc;
                            op_next    = vls_pkg::OP_F_CURVE;
                            state_next = vls_pkg::ST_READ;
                        end
                        vls_pkg::OP_F_CURVE:
                        begin
                            f_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_F_FD;
                        end
                        vls_pkg::OP_F_FD:
                        begin
                            f_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_F_RATIO;
                        end
                        vls_pkg::OP_F_RATIO:
                        begin
                            f_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_F_EFF;
                        end
                        vls_pkg::OP_F_EFF:
                        begin
                            f_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_F_DIV;
                        end
                        vls_pkg::OP_F_DIV:
                        begin
                            f_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_CAP;
                        end
                        vls_pkg::OP_CAP:
                        begin
                            // rear traction limit
                            if (f_reg > alu_rsp.result)
                            begin
                                f_next      = alu_rsp.result;
                                capped_next = 1'b1;
                            end
                            op_next = vls_pkg::OP_DRAG_SQ;
                        end
                        vls_pkg::OP_DRAG_SQ:
                        begin
                            t_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_DRAG;
                        end
                        vls_pkg::OP_DRAG:
                        begin
                            t_next  = alu_rsp.result;
                            op_next = vls_pkg::OP_ROLL;
                        end
                        vls_pkg::OP_ROLL:
                        begin
                            q_next  = net_sat;
                            op_next = vls_pkg::OP_ACC;
                        end
                        vls_pkg::OP_ACC:
                        begin
                            acc_next = alu_rsp.result[31:0];
                            op_next  = vls_pkg::OP_SPEED;
                        end
                        vls_pkg::OP_SPEED:
                        begin
                            speed_next = spd_sat;
                            op_next    = vls_pkg::OP_DIST;
                        end
                        vls_pkg::OP_DIST:
                        begin
                            dist_next  = dst_sat;
                            state_next = vls_pkg::ST_OUT;
                        end
                        default:
                        begin
                            state_next = vls_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            vls_pkg::ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = vls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vls_pkg::ST_IDLE;
            end
        endcase
    end

    // control state and plant state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vls_pkg::ST_IDLE;
            op_reg        <= vls_pkg::OP_RPM_DIV;
            out_valid_reg <= 1'b0;
            speed_reg     <= 32'sd0;
            dist_reg      <= 48'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            speed_reg     <= speed_next;
            dist_reg      <= dist_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rpm_reg    <= rpm_next;
        q_reg      <= q_next;
        f_reg      <= f_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        capped_reg <= capped_next;
        thr_reg    <= thr_next;
        dt_reg     <= dt_next;
        ratio_reg  <= ratio_next;
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rpm_reg    <= rpm_reg;
            out_force_reg  <= f_reg[47:0];
            out_acc_reg    <= acc_reg;
            out_speed_reg  <= speed_reg;
            out_dist_reg   <= dist_reg;
            out_capped_reg <= capped_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign engine_rpm      = out_rpm_reg;
    assign drive_force     = out_force_reg;
    assign accel_out       = out_acc_reg;
    assign speed_out       = out_speed_reg;
    assign distance_out    = out_dist_reg;
    assign traction_capped = out_capped_reg;

endmodule

`default_nettype wire

// File: tb/tb_vehicle_longitudinal_step.sv
// tb_vehicle_longitudinal_step: self-checking bench for the vehicle longitudinal step block
// depends on rtl/core/vls_pkg.sv and rtl/core/vehicle_longitudinal_step.sv
`default_nettype none

module tb_vehicle_longitudinal_step;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int         NUM_GEARS = 10;
    localparam int         NUM_RPM = 16384;
    localparam longint     SAT48 = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint     SAT32 = 64'h0000_0000_7FFF_FFFF;
    localparam longint     Q_EFF = 45875;
    localparam longint     Q_DRAG = 26493;
    localparam longint     Q_ROLL = 794788;
    localparam longint     Q_TRAC = 321126;
    localparam longint     Q_RPM = 625823;
    localparam longint     IDLE_RPM = 1000;
    localparam int         RANDOM_WORDS = 1900;
    localparam longint     CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [13:0] rpm;
        logic [47:0] force_n;
        logic [31:0] acc;
        logic [31:0] spd;
        logic [47:0] pos;
        logic        capped;
    } plant_out_t;

    typedef struct {
        logic [1:0]  kind;
        logic [16:0] thr;
        logic [3:0]  gear;
        logic [15:0] dt;
        logic [13:0] idx;
        logic [31:0] val;
        logic        typed;
        plant_out_t  want;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid, item_ready;
    logic [1:0]  kind;
    logic [16:0] throttle;
    logic [3:0]  gear_select;
    logic [15:0] time_step;
    logic [13:0] table_index;
    logic signed [31:0] table_value;
    logic        result_valid, result_ready;
    logic [13:0] engine_rpm;
    logic signed [47:0] drive_force;
    logic signed [31:0] accel_out;
    logic signed [31:0] speed_out;
    logic signed [47:0] distance_out;
    logic        traction_capped;

    // plant state as the bench sees it
    logic [14:0] rpm_max_reg;
    longint      fdrive_reg, radius_reg, mass_reg;
    longint      veh_speed, veh_dist;
    longint      curve_tab [NUM_RPM];
    bit          curve_set [NUM_RPM];
    longint      ratio_tab [NUM_GEARS];

    plant_out_t  pending_q [$];
    int          mismatches;
    longint      cycles;
    int          rdy_mode;

    vehicle_longitudinal_step i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready),
        .kind(kind), .throttle(throttle), .gear_select(gear_select),
        .time_step(time_step), .table_index(table_index), .table_value(table_value),
        .result_valid(result_valid), .result_ready(result_ready),
        .engine_rpm(engine_rpm), .drive_force(drive_force), .accel_out(accel_out),
        .speed_out(speed_out), .distance_out(distance_out),
        .traction_capped(traction_capped)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // truncating fixed point multiply, saturated to +-lim
    function automatic longint q_mul(longint a, longint b, longint lim);
        logic [127:0] ua, ub, prod;
        logic [63:0]  r;
        ua = {64'd0, (a < 0) ? -a : a};
        ub = {64'd0, (b < 0) ? -b : b};
        prod = (ua * ub) >> 16;
        r = (prod > lim) ? lim : prod[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // truncating fixed point divide, saturated to +-lim
    function automatic longint q_div(longint a, longint b, longint lim);
        logic [63:0] ua, ub, r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (ua > SAT48)
        begin
            ua = SAT48;
        end
        if (ua == 0)
        begin
            return 0;
        end
        if (ub == 0)
        begin
            r = lim;
        end
        else
        begin
            r = (ua << 16) / ub;
            if (r > lim)
            begin
                r = lim;
            end
        end
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint gear_ratio(logic [3:0] g);
        return (g < NUM_GEARS) ? ratio_tab[g] : 0;
    endfunction

    // curve index the next tick in gear g will look up
    function automatic longint lookup_rpm(logic [3:0] g);
        longint upper, q, r;
        upper = (rpm_max_reg == 0) ? 0 : longint'(rpm_max_reg) - 1;
        if (upper > NUM_RPM - 1)
        begin
            upper = NUM_RPM - 1;
        end
        if (g == 1)
        begin
            r = IDLE_RPM;
        end
        else
        begin
            q = q_div(veh_speed, radius_reg, SAT48);
            q = q_mul(q, gear_ratio(g), SAT48);
            q = q_mul(q, fdrive_reg, SAT48);
            q = q_mul(q, Q_RPM, SAT48);
            r = (q < (IDLE_RPM << 16)) ? IDLE_RPM : (q >>> 16);
        end
        return (r > upper) ? upper : r;
    endfunction

    // advance the plant by one word and return its result
    function automatic plant_out_t plant_step(logic [1:0] k, logic [16:0] thr, logic [3:0] g,
                                              logic [15:0] dt, logic [13:0] idx,
                                              logic [31:0] val);
        plant_out_t o;
        longint rpm, f, cap, drag, roll, net, acc, ratio;
        bit capped;
        rpm = 0;
        f = 0;
        acc = 0;
        capped = 0;
        if (k == vls_pkg::KIND_CURVE)
        begin
            curve_tab[idx] = longint'(signed'(val));
            curve_set[idx] = 1;
        end
        else if (k == vls_pkg::KIND_GEAR)
        begin
            if (idx < NUM_GEARS)
            begin
                ratio_tab[idx] = longint'(signed'(val));
            end
        end
        else if (k == vls_pkg::KIND_TICK)
        begin
            ratio = gear_ratio(g);
            rpm = lookup_rpm(g);
            f = q_mul(longint'(thr), curve_tab[rpm], SAT48);
            f = q_mul(f, fdrive_reg, SAT48);
            f = q_mul(f, ratio, SAT48);
            f = q_mul(f, Q_EFF, SAT48);
            f = q_div(f, radius_reg, SAT48);
            cap = q_mul(mass_reg, Q_TRAC, SAT48);
            if (f > cap)
            begin
                f = cap;
                capped = 1;
            end
            drag = q_mul(Q_DRAG, q_mul(veh_speed, (veh_speed < 0) ? -veh_speed : veh_speed,
                                       SAT48), SAT48);
            roll = q_mul(Q_ROLL, veh_speed, SAT48);
            net = clamp(f - drag - roll, SAT48);
            acc = q_div(net, mass_reg, SAT32);
            veh_speed = clamp(veh_speed + q_mul(longint'(dt), acc, SAT32), SAT32);
            veh_dist = clamp(veh_dist + q_mul(longint'(dt), veh_speed, SAT48), SAT48);
        end
        o.rpm = rpm[13:0];
        o.force_n = f[47:0];
        o.acc = acc[31:0];
        o.spd = veh_speed[31:0];
        o.pos = veh_dist[47:0];
        o.capped = capped;
        return o;
    endfunction

    // register write over the config port, setup then access
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            vls_pkg::REG_RPM_LIMIT:   rpm_max_reg = val[14:0];
            vls_pkg::REG_FINAL_DRIVE: fdrive_reg = longint'(val);
            vls_pkg::REG_WHEEL_RAD:   radius_reg = longint'(val);
            default:                  mass_reg = longint'(val);
        endcase
    endtask

    // present one word, wait for accept, then maybe leave a gap
    task automatic push_word(step_row_t w);
        plant_out_t exp_o;
        int gap;
        kind <= w.kind;
        throttle <= w.thr;
        gear_select <= w.gear;
        time_step <= w.dt;
        table_index <= w.idx;
        table_value <= w.val;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        exp_o = plant_step(w.kind, w.thr, w.gear, w.dt, w.idx, w.val);
        pending_q.push_back(w.typed ? w.want : exp_o);
        // bursty sender: mostly back to back, sometimes a gap
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // a tick never looks up a curve entry that was not loaded first
    task automatic push_checked(step_row_t w);
        step_row_t fill;
        longint r;
        if (w.kind == vls_pkg::KIND_TICK)
        begin
            r = lookup_rpm(w.gear);
            if (!curve_set[r])
            begin
                fill = '{vls_pkg::KIND_CURVE, 17'd0, 4'd0, 16'd0, r[13:0],
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000000),
                         1'b0, '0};
                push_word(fill);
            end
        end
        push_word(w);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic step_row_t rand_word();
        step_row_t w;
        int pick;
        w = '{KIND_NOP, 17'd0, 4'd0, 16'd0, 14'd0, 32'd0, 1'b0, '0};
        pick = $urandom_range(0, 99);
        w.thr = ($urandom_range(0, 7) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
        w.gear = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(2, 9));
        w.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6554));
        w.idx = 14'($urandom);
        w.val = $urandom;
        if (pick < 82)
        begin
            w.kind = vls_pkg::KIND_TICK;
        end
        else if (pick < 90)
        begin
            w.kind = vls_pkg::KIND_CURVE;
        end
        else if (pick < 97)
        begin
            w.kind = vls_pkg::KIND_GEAR;
            w.idx = 14'($urandom_range(0, 15));
            if ($urandom_range(0, 1))
            begin
                w.val = $urandom_range(0, 400000);
            end
        end
        return w;
    endfunction

    // receiver: ready pattern switches between always, random and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rdy_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 150) == 0)
            begin
                rdy_mode <= $urandom_range(0, 2);
            end
            case (rdy_mode)
                0:       result_ready <= 1'b1;
                1:       result_ready <= $urandom_range(0, 1);
                default: result_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        plant_out_t got, exp_o;
        if (rst_n && result_valid && result_ready)
        begin
            got = '{engine_rpm, drive_force, accel_out, speed_out, distance_out,
                    traction_capped};
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result word rpm=%0d speed=%h", engine_rpm, speed_out);
                end
            end
            else
            begin
                exp_o = pending_q.pop_front();
                if (got !== exp_o)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch rpm %0d/%0d force %h/%h acc %h/%h",
                                 exp_o.rpm, got.rpm, exp_o.force_n, got.force_n,
                                 exp_o.acc, got.acc);
                        $display("  speed %h/%h dist %h/%h capped %b/%b",
                                 exp_o.spd, got.spd, exp_o.pos, got.pos,
                                 exp_o.capped, got.capped);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        step_row_t dir_rows [$];
        step_row_t w;
        int phase;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        item_valid = 0;
        kind = '0;
        throttle = '0;
        gear_select = '0;
        time_step = '0;
        table_index = '0;
        table_value = '0;
        mismatches = 0;
        cycles = 0;
        rst_n = 0;
        rpm_max_reg = vls_pkg::RST_RPM_LIMIT;
        fdrive_reg = vls_pkg::RST_FINAL_DRIVE;
        radius_reg = vls_pkg::RST_WHEEL_RAD;
        mass_reg = vls_pkg::RST_MASS;
        veh_speed = 0;
        veh_dist = 0;
        foreach (curve_set[i]) curve_set[i] = 0;
        foreach (ratio_tab[i]) ratio_tab[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: kind, throttle, gear, dt, index, value, typed, result
        dir_rows = '{
            '{KIND_NOP, 17'h1FFFF, 4'd15, 16'hFFFF, 14'h3FFF, 32'hFFFF_FFFF, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd0, -32'sd229376, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd1, 32'd65536, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd2, 32'd229376, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd3, 32'd143360, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd4, 32'd98304, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd5, 32'd72000, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd6, 32'd58000, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd7, 32'd50000, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd8, 32'h7FFF_FFFF, 1'b1, '0},
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'd9, 32'h8000_0000, 1'b1, '0},
            // gear index beyond the table is dropped
            '{vls_pkg::KIND_GEAR, 0, 0, 0, 14'h3FFF, 32'd1, 1'b1, '0},
            '{vls_pkg::KIND_CURVE, 0, 0, 0, 14'd1000, 32'd9830400, 1'b1, '0},
            '{vls_pkg::KIND_CURVE, 0, 0, 0, 14'h3FFF, 32'h8000_0000, 1'b1, '0},
            // ticks: full throttle, zero, neutral, reverse, gear past table, dt extremes
            '{vls_pkg::KIND_TICK, 17'd65536, 4'd2, 16'hFFFF, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd65536, 4'd2, 16'd0, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd0, 4'd3, 16'd6554, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd65536, 4'd1, 16'd6554, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd65536, 4'd0, 16'hFFFF, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd65536, 4'd15, 16'hFFFF, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd65536, 4'd8, 16'hFFFF, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd65536, 4'd9, 16'hFFFF, 0, 0, 1'b0, '0},
            '{vls_pkg::KIND_TICK, 17'd32768, 4'd4, 16'hFFFF, 0, 0, 1'b0, '0}
        };
        foreach (dir_rows[i]) push_checked(dir_rows[i]);
        drain();

        // random phases, each under its own register setting
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(vls_pkg::REG_RPM_LIMIT, 32'd1001);
                    write_reg(vls_pkg::REG_FINAL_DRIVE, 32'd0);
                    write_reg(vls_pkg::REG_WHEEL_RAD, 32'd1);
                    write_reg(vls_pkg::REG_MASS, 32'd1);
                end
                1:
                begin
                    write_reg(vls_pkg::REG_RPM_LIMIT, 32'd16384);
                    write_reg(vls_pkg::REG_FINAL_DRIVE, 32'hFFFF_FFFF);
                    write_reg(vls_pkg::REG_WHEEL_RAD, 32'hFFFF_FFFF);
                    write_reg(vls_pkg::REG_MASS, 32'hFFFF_FFFF);
                end
                default:
                begin
                    write_reg(vls_pkg::REG_RPM_LIMIT, $urandom_range(1001, 16384));
                    write_reg(vls_pkg::REG_FINAL_DRIVE, $urandom_range(131072, 393216));
                    write_reg(vls_pkg::REG_WHEEL_RAD, $urandom_range(13107, 32768));
                    write_reg(vls_pkg::REG_MASS, $urandom_range(32768000, 131072000));
                end
            endcase
            // close the config transfer
            psel <= 1'b0;
            penable <= 1'b0;
            repeat (RANDOM_WORDS / 5)
            begin
                w = rand_word();
                push_checked(w);
            end
            drain();
        end

        if (mismatches == 0 && pending_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
